>>> sv/box_cluster_bounds_core_macros.svh
// ----------------------------------------------------------------------------
// Box cluster bounds: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOX_CLUSTER_BOUNDS_CORE_MACROS_SVH
`define BOX_CLUSTER_BOUNDS_CORE_MACROS_SVH

// implication that must hold whenever the block is out of reset
`define CBB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication checked in the cycle after the antecedent
`define CBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/cbb_pkg.sv
// ----------------------------------------------------------------------------
// Box cluster bounds package
// Constants and shared types for the front end, queue and cluster engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package cbb_pkg;
  localparam int CBB_MAX_BOXES   = 64;
  localparam int CBB_COORD_BITS  = 24;
  localparam int GAP_W           = 12;
  localparam int MEMBER_W        = 7;
  localparam int QUEUE_DEPTH     = 4;
  localparam logic [GAP_W-1:0] GAP_RESET = 12'd640;

  // classification of one request on its way to the engine
  typedef struct packed {
    logic keep;
    logic last;
  } cbb_tag_t;

  localparam int TAG_W = $bits(cbb_tag_t);
endpackage

>>> sv/cbb_queue.sv
// ----------------------------------------------------------------------------
// Box cluster bounds: request queue
// Short register queue between the front end and the cluster engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cbb_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  import cbb_pkg::*;

  localparam int QP_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]    q_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_r;
  logic [QP_W-1:0] rd_ptr_r;
  logic [QC_W-1:0] cnt_r;

  assign full  = (cnt_r == QC_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      q_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= (rd_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QC_W'(push && !full) - QC_W'(pop && !empty);
    end
  end
endmodule

>>> sv/cbb_front.sv
// ----------------------------------------------------------------------------
// Box cluster bounds: front end
// Accepts box requests, marks each as stored or dropped for capacity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cbb_front #(
  parameter int MAX_BOXES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              last_box,
  output cbb_pkg::cbb_tag_t tag
);
  import cbb_pkg::*;

  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  logic [CNT_W-1:0] set_cnt_r;
  logic             room;

  assign room     = (set_cnt_r != CNT_W'(MAX_BOXES));
  assign tag.keep = room;
  assign tag.last = last_box;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_cnt_r <= '0;
    end else if (accept) begin
      // restart the count once the set closes
      if (last_box) begin
        set_cnt_r <= '0;
      end else if (room) begin
        set_cnt_r <= set_cnt_r + 1'b1;
      end
    end
  end
endmodule

>>> sv/cbb_back.sv
// ----------------------------------------------------------------------------
// Box cluster bounds: cluster engine
// Stores boxes, scans for the largest-volume seed and grows the cluster.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "box_cluster_bounds_core_macros.svh"
module cbb_back #(
  parameter int MAX_BOXES  = 64,
  parameter int COORD_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [cbb_pkg::GAP_W-1:0]         gap,
  input  logic                              q_empty,
  input  logic [6*COORD_BITS+cbb_pkg::TAG_W-1:0] q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  output logic signed [COORD_BITS-1:0]      out_lo [3],
  output logic signed [COORD_BITS-1:0]      out_hi [3],
  output logic [cbb_pkg::MEMBER_W-1:0]      out_count,
  output logic                              out_drop
);
  import cbb_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int BOX_W = 6 * CB;
  localparam int IDX_W = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int EXT_W = CB + 1;
  localparam int VOL_W = 3 * CB;

  typedef enum logic [3:0] {
    ST_IDLE, ST_S_RD, ST_S_EXT, ST_S_M1, ST_S_M2, ST_S_M3, ST_S_SUM, ST_S_CMP,
    ST_G_SRD, ST_G_SLD, ST_G_RD, ST_G_EV, ST_DONE
  } state_t;

  state_t state_r;

  logic [BOX_W-1:0] mem [MAX_BOXES];
  logic [BOX_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;

  cbb_tag_t         q_tag;
  logic [BOX_W-1:0] q_box;

  logic [CNT_W-1:0] wr_cnt_r;
  logic             drop_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] seed_r;
  logic             is_end;

  logic [CB-1:0]          mag_r [3];
  logic                   neg_r;
  logic [2*CB-1:0]        p_r;
  logic [2*CB-1:0]        plo_r;
  logic [2*CB-1:0]        phi_r;
  logic signed [VOL_W:0]  vol_r;
  logic signed [VOL_W:0]  best_r;

  logic [CB-1:0] mag_c [3];
  logic [2:0]    neg_c;

  logic signed [CB-1:0] clo_r [3];
  logic signed [CB-1:0] chi_r [3];
  logic [MAX_BOXES-1:0] flags_r;
  logic [CNT_W-1:0]     members_r;
  logic                 grew_r;

  logic                 join_c;
  logic signed [CB-1:0] clo_c [3];
  logic signed [CB-1:0] chi_c [3];

  assign q_tag = q_data[BOX_W +: TAG_W];
  assign q_box = q_data[BOX_W-1:0];
  assign q_pop = (state_r == ST_IDLE) && !q_empty;
  assign is_end = (CNT_W'(idx_r) + CNT_W'(1) == wr_cnt_r);

  always_comb begin
    unique case (state_r)
      ST_G_SRD: rd_addr = seed_r;
      default:  rd_addr = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_tag.keep) begin
      mem[wr_cnt_r[IDX_W-1:0]] <= q_box;
    end
    rd_data_r <= mem[rd_addr];
  end

  // signed extents and their magnitudes
  always_comb begin
    logic signed [EXT_W-1:0] lo_e;
    logic signed [EXT_W-1:0] hi_e;
    logic signed [EXT_W-1:0] d;
    logic signed [EXT_W-1:0] m;
    for (int k = 0; k < 3; k++) begin
      lo_e = EXT_W'($signed(rd_data_r[k*CB +: CB]));
      hi_e = EXT_W'($signed(rd_data_r[(k+3)*CB +: CB]));
      d    = hi_e - lo_e;
      neg_c[k] = d[EXT_W-1];
      m    = neg_c[k] ? -d : d;
      mag_c[k] = m[CB-1:0];
    end
  end

  // membership test and widened bounds for the box in rd_data_r
  always_comb begin
    logic signed [EXT_W-1:0] g_e;
    logic signed [CB-1:0]    lo;
    logic signed [CB-1:0]    hi;
    logic signed [CB-1:0]    mn;
    logic signed [CB-1:0]    mx;
    g_e    = EXT_W'(gap);
    join_c = !flags_r[idx_r];
    for (int k = 0; k < 3; k++) begin
      lo = $signed(rd_data_r[k*CB +: CB]);
      hi = $signed(rd_data_r[(k+3)*CB +: CB]);
      if (EXT_W'(lo) - g_e > EXT_W'(chi_r[k])) join_c = 1'b0;
      if (EXT_W'(hi) + g_e < EXT_W'(clo_r[k])) join_c = 1'b0;
      mn = (lo < hi) ? lo : hi;
      mx = (lo > hi) ? lo : hi;
      clo_c[k] = (mn < clo_r[k]) ? mn : clo_r[k];
      chi_c[k] = (mx > chi_r[k]) ? mx : chi_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      wr_cnt_r  <= '0;
      drop_r    <= 1'b0;
      idx_r     <= '0;
      seed_r    <= '0;
      flags_r   <= '0;
      members_r <= '0;
      grew_r    <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            if (q_tag.keep) begin
              wr_cnt_r <= wr_cnt_r + 1'b1;
            end else begin
              drop_r <= 1'b1;
            end
            if (q_tag.last) begin
              idx_r   <= '0;
              state_r <= ST_S_RD;
            end
          end
        end
        ST_S_RD:  state_r <= ST_S_EXT;
        ST_S_EXT: begin
          mag_r   <= mag_c;
          neg_r   <= ^neg_c;
          state_r <= ST_S_M1;
        end
        ST_S_M1: begin
          p_r     <= mag_r[0] * mag_r[1];
          state_r <= ST_S_M2;
        end
        ST_S_M2: begin
          plo_r   <= p_r[CB-1:0] * mag_r[2];
          state_r <= ST_S_M3;
        end
        ST_S_M3: begin
          phi_r   <= p_r[2*CB-1:CB] * mag_r[2];
          state_r <= ST_S_SUM;
        end
        ST_S_SUM: begin
          vol_r <= neg_r
                 ? -$signed({1'b0, (VOL_W'(phi_r) << CB) + VOL_W'(plo_r)})
                 :  $signed({1'b0, (VOL_W'(phi_r) << CB) + VOL_W'(plo_r)});
          state_r <= ST_S_CMP;
        end
        ST_S_CMP: begin
          // strict compare keeps the earliest box on a tie
          if (idx_r == '0 || vol_r > best_r) begin
            best_r <= vol_r;
            seed_r <= idx_r;
          end
          if (is_end) begin
            state_r <= ST_G_SRD;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= ST_S_RD;
          end
        end
        ST_G_SRD: state_r <= ST_G_SLD;
        ST_G_SLD: begin
          for (int k = 0; k < 3; k++) begin
            clo_r[k] <= $signed(rd_data_r[k*CB +: CB]);
            chi_r[k] <= $signed(rd_data_r[(k+3)*CB +: CB]);
          end
          flags_r         <= MAX_BOXES'(1) << seed_r;
          members_r       <= CNT_W'(1);
          idx_r           <= '0;
          grew_r          <= 1'b0;
          state_r         <= ST_G_RD;
        end
        ST_G_RD: state_r <= ST_G_EV;
        ST_G_EV: begin
          if (join_c) begin
            clo_r          <= clo_c;
            chi_r          <= chi_c;
            flags_r[idx_r] <= 1'b1;
            members_r      <= members_r + 1'b1;
          end
          if (is_end) begin
            // run another pass while any box joined in this one
            if (grew_r || join_c) begin
              idx_r   <= '0;
              grew_r  <= 1'b0;
              state_r <= ST_G_RD;
            end else begin
              state_r <= ST_DONE;
            end
          end else begin
            grew_r  <= grew_r || join_c;
            idx_r   <= idx_r + 1'b1;
            state_r <= ST_G_RD;
          end
        end
        ST_DONE: begin
          wr_cnt_r <= '0;
          drop_r   <= 1'b0;
          flags_r  <= '0;
          state_r  <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = (state_r == ST_DONE);
  assign out_lo    = clo_r;
  assign out_hi    = chi_r;
  assign out_count = MEMBER_W'(members_r);
  assign out_drop  = drop_r;

  `CBB_ASSERT_NEXT(a_single_pulse, out_valid, !out_valid, "result strobe longer than one cycle")
  `CBB_ASSERT_IMP(a_count_nonzero, out_valid, members_r != '0, "empty cluster reported")
  `CBB_ASSERT_IMP(a_store_bound, 1'b1, wr_cnt_r <= CNT_W'(MAX_BOXES), "store count past capacity")
  `CBB_ASSERT_IMP(a_members_bound, out_valid, members_r <= wr_cnt_r, "more members than boxes")
endmodule

>>> sv/box_cluster_bounds_core.sv
// Box cluster bounds core. Boxes are requested one per cycle while busy is low;
// each waits in a four-entry queue and is written to the box store when the engine
// pops it. After the last box of a set the engine takes every stored box through the
// seed scan states read, extent, multiply, sum and compare (the three 24-bit volume
// multiplies run in successive cycles), then reads each stored box on every growth
// pass through the single store read port, passes repeating until none adds a box.
// The result is shown for one cycle on out_valid and must be taken then; busy rises
// only when the queue is full.
// ----------------------------------------------------------------------------
// Box cluster bounds top level
// Configuration register, front end, request queue and cluster engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module box_cluster_bounds_core #(
  parameter int MAX_BOXES  = cbb_pkg::CBB_MAX_BOXES,
  parameter int COORD_BITS = cbb_pkg::CBB_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cbb_pkg::GAP_W-1:0]     cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  in_box_min_x,
  input  logic signed [COORD_BITS-1:0]  in_box_min_y,
  input  logic signed [COORD_BITS-1:0]  in_box_min_z,
  input  logic signed [COORD_BITS-1:0]  in_box_max_x,
  input  logic signed [COORD_BITS-1:0]  in_box_max_y,
  input  logic signed [COORD_BITS-1:0]  in_box_max_z,
  input  logic                          in_last_box,
  output logic                          out_valid,
  output logic signed [COORD_BITS-1:0]  out_cluster_min_x,
  output logic signed [COORD_BITS-1:0]  out_cluster_min_y,
  output logic signed [COORD_BITS-1:0]  out_cluster_min_z,
  output logic signed [COORD_BITS-1:0]  out_cluster_max_x,
  output logic signed [COORD_BITS-1:0]  out_cluster_max_y,
  output logic signed [COORD_BITS-1:0]  out_cluster_max_z,
  output logic [cbb_pkg::MEMBER_W-1:0]  out_member_count,
  output logic                          out_overflowed
);
  import cbb_pkg::*;

  localparam int Q_W = 6 * COORD_BITS + TAG_W;

  logic [GAP_W-1:0] gap_r;
  logic             accept;
  cbb_tag_t         tag;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic [Q_W-1:0]   q_din;
  logic [Q_W-1:0]   q_dout;
  logic signed [COORD_BITS-1:0] lo [3];
  logic signed [COORD_BITS-1:0] hi [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= GAP_RESET;
    end else if (cfg_we) begin
      gap_r <= cfg_wdata;
    end
  end

  assign busy   = q_full;
  assign accept = start && !busy;
  assign q_din  = {tag, in_box_max_z, in_box_max_y, in_box_max_x,
                   in_box_min_z, in_box_min_y, in_box_min_x};

  cbb_front #(.MAX_BOXES(MAX_BOXES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .last_box (in_last_box),
    .tag      (tag)
  );

  cbb_queue #(.W(Q_W)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  cbb_back #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .gap       (gap_r),
    .q_empty   (q_empty),
    .q_data    (q_dout),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_lo    (lo),
    .out_hi    (hi),
    .out_count (out_member_count),
    .out_drop  (out_overflowed)
  );

  assign out_cluster_min_x = lo[0];
  assign out_cluster_min_y = lo[1];
  assign out_cluster_min_z = lo[2];
  assign out_cluster_max_x = hi[0];
  assign out_cluster_max_y = hi[1];
  assign out_cluster_max_z = hi[2];
endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box cluster bounds testbench
// Streams sets of boxes into the core under varied stall patterns and gap
// settings, predicts each cluster in the bench and checks every result.
// ----------------------------------------------------------------------------
module testbench;
  import cbb_pkg::*;

  localparam int CB = CBB_COORD_BITS;
  localparam int NB = CBB_MAX_BOXES;

  typedef struct packed {
    logic [2:0][CB-1:0] lo;
    logic [2:0][CB-1:0] hi;
    logic               last;
  } box_req_t;

  typedef struct packed {
    logic [2:0][CB-1:0]   cmin;
    logic [2:0][CB-1:0]   cmax;
    logic [MEMBER_W-1:0]  count;
    logic                 ovf;
  } cluster_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [GAP_W-1:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic signed [CB-1:0] in_box_min_x = '0, in_box_min_y = '0, in_box_min_z = '0;
  logic signed [CB-1:0] in_box_max_x = '0, in_box_max_y = '0, in_box_max_z = '0;
  logic in_last_box = 1'b0;
  logic out_valid;
  logic signed [CB-1:0] out_cluster_min_x, out_cluster_min_y, out_cluster_min_z;
  logic signed [CB-1:0] out_cluster_max_x, out_cluster_max_y, out_cluster_max_z;
  logic [MEMBER_W-1:0] out_member_count;
  logic out_overflowed;

  box_cluster_bounds_core i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy),
    .in_box_min_x(in_box_min_x), .in_box_min_y(in_box_min_y),
    .in_box_min_z(in_box_min_z), .in_box_max_x(in_box_max_x),
    .in_box_max_y(in_box_max_y), .in_box_max_z(in_box_max_z),
    .in_last_box(in_last_box), .out_valid(out_valid),
    .out_cluster_min_x(out_cluster_min_x), .out_cluster_min_y(out_cluster_min_y),
    .out_cluster_min_z(out_cluster_min_z), .out_cluster_max_x(out_cluster_max_x),
    .out_cluster_max_y(out_cluster_max_y), .out_cluster_max_z(out_cluster_max_z),
    .out_member_count(out_member_count), .out_overflowed(out_overflowed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  box_req_t pending_boxes[$];
  cluster_t expected_clusters[$];
  box_req_t cur_box;
  int idle_pct = 0;
  int errs = 0;

  // bench copy of the block state
  logic [GAP_W-1:0] gap_q = GAP_RESET;
  logic signed [CB-1:0] st_lo[NB][3], st_hi[NB][3];
  int stored = 0;
  bit dropped = 0;

  function automatic logic signed [79:0] box_volume(int i);
    logic signed [79:0] d[3];
    for (int k = 0; k < 3; k++) d[k] = 80'(longint'(st_hi[i][k]) - longint'(st_lo[i][k]));
    return d[0] * d[1] * d[2];
  endfunction

  task automatic absorb_box(input box_req_t b);
    logic signed [79:0] v, best;
    int seed, members;
    longint c0[3], c1[3], a0, a1, g;
    bit mem[NB];
    bit grew, fits;
    cluster_t r;
    if (stored < NB) begin
      for (int k = 0; k < 3; k++) begin
        st_lo[stored][k] = b.lo[k];
        st_hi[stored][k] = b.hi[k];
      end
      stored++;
    end else begin
      dropped = 1;
    end
    if (!b.last) return;
    g = longint'(gap_q);
    seed = 0;
    best = box_volume(0);
    for (int i = 1; i < stored; i++) begin
      v = box_volume(i);
      if (v > best) begin
        best = v;
        seed = i;
      end
    end
    foreach (mem[i]) mem[i] = 0;
    mem[seed] = 1;
    for (int k = 0; k < 3; k++) begin
      c0[k] = st_lo[seed][k];
      c1[k] = st_hi[seed][k];
    end
    grew = 1;
    while (grew) begin
      grew = 0;
      for (int i = 0; i < stored; i++) begin
        if (mem[i]) continue;
        fits = 1;
        for (int k = 0; k < 3; k++)
          if (!(longint'(st_lo[i][k]) - g <= c1[k] && longint'(st_hi[i][k]) + g >= c0[k]))
            fits = 0;
        if (!fits) continue;
        mem[i] = 1;
        grew = 1;
        for (int k = 0; k < 3; k++) begin
          a0 = st_lo[i][k];
          a1 = st_hi[i][k];
          if (a0 < c0[k]) c0[k] = a0;
          if (a1 < c0[k]) c0[k] = a1;
          if (a0 > c1[k]) c1[k] = a0;
          if (a1 > c1[k]) c1[k] = a1;
        end
      end
    end
    members = 0;
    for (int i = 0; i < stored; i++) if (mem[i]) members++;
    for (int k = 0; k < 3; k++) begin
      r.cmin[k] = c0[k][CB-1:0];
      r.cmax[k] = c1[k][CB-1:0];
    end
    r.count = members[MEMBER_W-1:0];
    r.ovf = dropped;
    expected_clusters = {expected_clusters, r};
    stored = 0;
    dropped = 0;
  endtask

  // driver
  always @(posedge clk) begin
    box_req_t nb;
    logic nxt_start;
    if (rst_n) begin
      nxt_start = start;
      nb = cur_box;
      if (start && !busy) begin
        absorb_box(cur_box);
        void'(pending_boxes.pop_front());
        nxt_start = 1'b0;
      end
      if (!nxt_start && pending_boxes.size() > 0 && $urandom_range(99) >= idle_pct) begin
        nb = pending_boxes[0];
        nxt_start = 1'b1;
      end
      cur_box <= nb;
      start <= nxt_start;
      in_box_min_x <= nb.lo[0];
      in_box_min_y <= nb.lo[1];
      in_box_min_z <= nb.lo[2];
      in_box_max_x <= nb.hi[0];
      in_box_max_y <= nb.hi[1];
      in_box_max_z <= nb.hi[2];
      in_last_box <= nb.last;
    end
  end

  // monitor
  always @(posedge clk) begin
    cluster_t act, exp_c;
    if (rst_n && out_valid) begin
      act.cmin = {out_cluster_min_z, out_cluster_min_y, out_cluster_min_x};
      act.cmax = {out_cluster_max_z, out_cluster_max_y, out_cluster_max_x};
      act.count = out_member_count;
      act.ovf = out_overflowed;
      if (expected_clusters.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected result %h", act);
      end else begin
        exp_c = expected_clusters.pop_front();
        if (act.cmin !== exp_c.cmin || act.cmax !== exp_c.cmax ||
            act.count !== exp_c.count || act.ovf !== exp_c.ovf) begin
          errs++;
          if (errs <= 10)
            $display("mismatch: exp min %h max %h n %0d ovf %b / got min %h max %h n %0d ovf %b",
                     exp_c.cmin, exp_c.cmax, exp_c.count, exp_c.ovf,
                     act.cmin, act.cmax, act.count, act.ovf);
        end
      end
    end
  end

  function automatic logic [CB-1:0] rnd_coord();
    return CB'($urandom);
  endfunction

  task automatic push_box(input logic [CB-1:0] l0, l1, l2, h0, h1, h2, input logic lst);
    box_req_t b;
    b.lo = {l2, l1, l0};
    b.hi = {h2, h1, h0};
    b.last = lst;
    pending_boxes = {pending_boxes, b};
  endtask

  // one set of n boxes, most scattered around a common centre
  task automatic push_set(input int n);
    int spread, base[3], lo[3], hi[3], ext;
    spread = 1 << $urandom_range(14, 6);
    for (int k = 0; k < 3; k++) base[k] = $signed(CB'($urandom)) / 2;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(7) == 0) begin
        push_box(rnd_coord(), rnd_coord(), rnd_coord(),
                 rnd_coord(), rnd_coord(), rnd_coord(), i == n - 1);
      end else begin
        for (int k = 0; k < 3; k++) begin
          lo[k] = base[k] + $urandom_range(2 * spread) - spread;
          ext = $urandom_range(spread);
          // occasionally invert or flatten the box
          case ($urandom_range(15))
            0: hi[k] = lo[k] - ext;
            1: hi[k] = lo[k];
            default: hi[k] = lo[k] + ext;
          endcase
        end
        push_box(CB'(lo[0]), CB'(lo[1]), CB'(lo[2]),
                 CB'(hi[0]), CB'(hi[1]), CB'(hi[2]), i == n - 1);
      end
    end
  endtask

  task automatic drain_and_set_gap(input logic [GAP_W-1:0] v);
    while (pending_boxes.size() != 0 || start || expected_clusters.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    gap_q = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int items;
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // directed sets at the reset gap
    push_box(24'h800000, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h7fffff, 1);
    push_box(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000, 24'h800000, 1);
    push_box(100, 100, 100, 50, 300, 300, 0);   // inverted on x
    push_box(0, 0, 0, 0, 500, 500, 0);         // flat
    push_box(600, 0, 0, 700, 10, 10, 1);
    push_box(0, 0, 0, 16, 16, 16, 0);           // tie of equal volumes
    push_box(5000, 0, 0, 5016, 16, 16, 0);
    push_box(656, 0, 0, 672, 16, 16, 1);
    push_box(0, 0, 0, 16, 16, 16, 1);
    drain_and_set_gap(0);
    push_box(0, 0, 0, 16, 16, 16, 0);
    push_box(16, 16, 16, 32, 32, 32, 0);        // touches with zero gap
    push_box(33, 0, 0, 40, 16, 16, 1);
    drain_and_set_gap(12'hfff);
    push_box(0, 0, 0, 16, 16, 16, 0);
    push_box(4111, 0, 0, 4200, 16, 16, 0);
    push_box(4113, 0, 0, 4200, 16, 16, 1);
    items = 0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 46 : (ph == 3) ? 14 : 0;
      case (ph)
        0: drain_and_set_gap(GAP_RESET);
        1: drain_and_set_gap(0);
        2: drain_and_set_gap(12'hfff);
        default: drain_and_set_gap(GAP_W'($urandom));
      endcase
      while (items < (ph + 1) * 360) begin
        n = ($urandom_range(39) == 0) ? $urandom_range(70, 63) : $urandom_range(8, 1);
        push_set(n);
        items += n;
        // keep the queue short so the idling pattern stays live
        while (pending_boxes.size() > 16) @(posedge clk);
      end
    end
    while (pending_boxes.size() != 0 || start || expected_clusters.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    errs += expected_clusters.size();
    if (errs == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: errors");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+sv
sv/cbb_pkg.sv
sv/cbb_queue.sv
sv/cbb_front.sv
sv/cbb_back.sv
sv/box_cluster_bounds_core.sv
bench/testbench.sv
